// ----- sv/cbv_pkg.sv -----
`default_nettype none
package cbv_pkg;
  localparam int unsigned MaxDepthDefault = 16;
  localparam int unsigned LengthBitsDefault = 16;
  localparam int unsigned CountBits = 17;

  typedef enum logic [2:0] {
    PH_IDLE, PH_HEAD, PH_ARG, PH_PAYLOAD, PH_OK, PH_ERR
  } phase_e;

  typedef enum logic [1:0] {
    ST_OPEN  = 2'd0,
    ST_VALID = 2'd1,
    ST_BAD   = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CT_IDLE, CT_BYTE, CT_POP, CT_SEND
  } ctrl_e;

  // Command from controller to datapath.
  typedef struct packed {
    logic load;   // capture input beat
    logic step;   // process captured byte
    logic pop;    // run one pop iteration
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic pop_more;  // pop sequence still running
  } sts_t;
endpackage
`default_nettype wire

// ----- sv/cbv_datapath.sv -----
`default_nettype none
module cbv_datapath #(
  parameter int unsigned MaxDepth   = cbv_pkg::MaxDepthDefault,
  parameter int unsigned LengthBits = cbv_pkg::LengthBitsDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic [15:0] bytes_after_i,
  input  wire logic        start_req_i,
  input  wire cbv_pkg::cmd_t cmd_i,
  output cbv_pkg::sts_t    sts_o,
  output logic [1:0]       status_o
);
  import cbv_pkg::*;

  localparam int unsigned LvlBits = $clog2(MaxDepth + 1);
  localparam int unsigned IdxBits = (MaxDepth > 1) ? $clog2(MaxDepth) : 1;
  localparam int unsigned RemBits = (LengthBits < 16) ? LengthBits : 16;

  phase_e phase_q, phase_d;
  logic [2:0]  major_q, major_d;
  logic [63:0] arg_q, arg_d;
  logic [3:0]  abl_q, abl_d;
  logic [3:0]  aw_q, aw_d;
  logic [15:0] pbl_q, pbl_d;
  logic [LvlBits-1:0] lvl_q, lvl_d;
  logic [CountBits-1:0] cnt_q [MaxDepth];
  logic        cnt_we;
  logic [IdxBits-1:0] cnt_wa;
  logic [CountBits-1:0] cnt_wd;
  logic [7:0]  byte_q;
  logic [RemBits-1:0] rem_q;
  logic        start_q;
  logic [1:0]  st_q, st_d;
  logic        pop_q, pop_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      major_q <= '0;
      arg_q   <= '0;
      abl_q   <= '0;
      aw_q    <= '0;
      pbl_q   <= '0;
      lvl_q   <= '0;
      st_q    <= ST_OPEN;
      pop_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      major_q <= major_d;
      arg_q   <= arg_d;
      abl_q   <= abl_d;
      aw_q    <= aw_d;
      pbl_q   <= pbl_d;
      lvl_q   <= lvl_d;
      st_q    <= st_d;
      pop_q   <= pop_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      byte_q  <= data_byte_i;
      rem_q   <= bytes_after_i[RemBits-1:0];
      start_q <= start_req_i;
    end
    if (cnt_we) begin
      cnt_q[cnt_wa] <= cnt_wd;
    end
  end

  logic [2:0]  mt;
  logic [4:0]  ai;
  logic [3:0]  need;
  logic [63:0] rem64, a, argn;
  logic [IdxBits-1:0] top;
  logic [CountBits-1:0] topc, topn;
  logic        head_ok;  // head complete path requested
  logic        elem;     // element done requested

  always_comb begin
    phase_d = phase_q;
    major_d = major_q;
    arg_d   = arg_q;
    abl_d   = abl_q;
    aw_d    = aw_q;
    pbl_d   = pbl_q;
    lvl_d   = lvl_q;
    st_d    = st_q;
    pop_d   = 1'b0;
    cnt_we  = 1'b0;
    cnt_wa  = lvl_q[IdxBits-1:0];
    cnt_wd  = '0;
    head_ok = 1'b0;
    elem    = 1'b0;
    mt      = byte_q[7:5];
    ai      = byte_q[4:0];
    need    = 4'd0;
    rem64   = 64'(rem_q);
    argn    = {arg_q[55:0], byte_q};
    a       = 64'(ai);
    top     = IdxBits'(lvl_q - LvlBits'(1));
    topc    = cnt_q[top];
    topn    = (topc != '0) ? topc - CountBits'(1) : topc;

    if (cmd_i.step) begin
      // Restart on a start beat.
      if (start_q) begin
        lvl_d   = '0;
        abl_d   = '0;
        pbl_d   = '0;
        phase_d = PH_HEAD;
      end
      st_d = ST_OPEN;
      unique case (start_q ? PH_HEAD : phase_q)
        PH_HEAD: begin
          need = (ai < 5'd24) ? 4'd0 : 4'(4'd1 << ai[1:0]);
          if ((32'(start_q ? '0 : lvl_q) + 1 > MaxDepth) || ai >= 5'd28 ||
              mt == 3'd1 || mt == 3'd6 || 64'(need) > rem64) begin
            phase_d = PH_ERR;
            st_d    = ST_BAD;
          end else begin
            major_d = mt;
            if (need == 4'd0) begin
              arg_d   = a;
              head_ok = 1'b1;
            end else begin
              arg_d   = '0;
              abl_d   = need;
              aw_d    = need;
              phase_d = PH_ARG;
            end
          end
        end
        PH_ARG: begin
          arg_d = argn;
          a     = argn;
          abl_d = (abl_q != 4'd0) ? abl_q - 4'd1 : abl_q;
          if (abl_d == 4'd0) begin
            if (major_q != 3'd7 &&
                ((aw_q == 4'd1 && a < 64'd24) || (aw_q == 4'd2 && a <= 64'hff) ||
                 (aw_q == 4'd4 && a <= 64'hffff) ||
                 (aw_q == 4'd8 && a <= 64'hffff_ffff))) begin
              phase_d = PH_ERR;
              st_d    = ST_BAD;
            end else begin
              head_ok = 1'b1;
            end
          end
        end
        PH_PAYLOAD: begin
          pbl_d = (pbl_q != '0) ? pbl_q - 16'd1 : pbl_q;
          if (pbl_d == '0) elem = 1'b1;
        end
        PH_OK: st_d = ST_VALID;
        PH_IDLE, PH_ERR: st_d = ST_BAD;
        default: st_d = ST_BAD;
      endcase

      if (head_ok) begin
        unique case (major_d)
          3'd0: elem = 1'b1;
          3'd2, 3'd3: begin
            if (a > rem64) begin
              phase_d = PH_ERR;
              st_d    = ST_BAD;
            end else if (a == '0) begin
              elem = 1'b1;
            end else begin
              pbl_d   = a[15:0];
              phase_d = PH_PAYLOAD;
            end
          end
          3'd4, 3'd5: begin
            if ((major_d == 3'd4) ? (a > rem64) : (a > (rem64 >> 1))) begin
              phase_d = PH_ERR;
              st_d    = ST_BAD;
            end else if (a == '0) begin
              elem = 1'b1;
            end else if (32'(lvl_d) >= MaxDepth) begin
              phase_d = PH_ERR;
              st_d    = ST_BAD;
            end else begin
              cnt_we  = 1'b1;
              cnt_wa  = lvl_d[IdxBits-1:0];
              cnt_wd  = (major_d == 3'd4) ? a[CountBits-1:0]
                                          : {a[CountBits-2:0], 1'b0};
              lvl_d   = lvl_d + LvlBits'(1);
              phase_d = PH_HEAD;
            end
          end
          3'd7: begin
            if (a == 64'd20 || a == 64'd21 || a == 64'd22) begin
              elem = 1'b1;
            end else begin
              phase_d = PH_ERR;
              st_d    = ST_BAD;
            end
          end
          default: begin
            phase_d = PH_ERR;
            st_d    = ST_BAD;
          end
        endcase
      end

      if (elem) begin
        // Close containers one level per pop cycle.
        if (lvl_d == '0) begin
          phase_d = PH_OK;
          st_d    = ST_VALID;
        end else begin
          pop_d = 1'b1;
        end
      end
      if (!pop_d && st_d == ST_OPEN && rem_q == '0 && phase_q != PH_OK) begin
        phase_d = PH_ERR;
        st_d    = ST_BAD;
      end
    end else if (cmd_i.pop) begin
      cnt_we = 1'b1;
      cnt_wa = top;
      cnt_wd = topn;
      if (topn != '0) begin
        phase_d = PH_HEAD;
        st_d    = (rem_q == '0) ? ST_BAD : ST_OPEN;
        if (rem_q == '0) phase_d = PH_ERR;
      end else begin
        lvl_d = lvl_q - LvlBits'(1);
        if (lvl_d == '0) begin
          phase_d = PH_OK;
          st_d    = ST_VALID;
        end else begin
          pop_d = 1'b1;
        end
      end
    end else begin
      pop_d = pop_q;
    end
  end

  assign sts_o.pop_more = pop_q;
  assign status_o = st_q;

`ifndef NO_ASSERTIONS
  a_lvl_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(lvl_q) <= MaxDepth) else $error("nesting level out of range");
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q != 2'd3) else $error("illegal status code");
  a_pop_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_q |-> lvl_q != '0) else $error("pop with no open container");
`endif
endmodule
`default_nettype wire

// ----- sv/cbv_ctrl.sv -----
`default_nettype none
module cbv_ctrl (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  input  wire cbv_pkg::sts_t sts_i,
  output cbv_pkg::cmd_t cmd_o
);
  import cbv_pkg::*;

  ctrl_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= CT_IDLE;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      CT_IDLE: if (in_valid_i) state_d = CT_BYTE;
      CT_BYTE: state_d = CT_POP;
      CT_POP:  if (!sts_i.pop_more) state_d = CT_SEND;
      CT_SEND: if (!out_stall_i) state_d = CT_IDLE;
      default: state_d = CT_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_stall_o  = (state_q != CT_IDLE);
    out_valid_o = (state_q == CT_SEND);
    unique case (state_q)
      CT_IDLE: cmd_o.load = in_valid_i;
      CT_BYTE: cmd_o.step = 1'b1;
      CT_POP:  cmd_o.pop  = sts_i.pop_more;
      CT_SEND: ;
      default: ;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load, cmd_o.step, cmd_o.pop})) else $error("command clash");
  a_step_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> cmd_o.step) else $error("load not followed by step");
  a_send_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o) else $error("result dropped");
`endif
endmodule
`default_nettype wire

// ----- sv/cbor_item_skip_validator.sv -----
`default_nettype none
// CBOR item validator, restricted profile: feed one buffer byte per input
// beat with the count of bytes behind it and a start flag; each beat
// returns one status beat (0 open, 1 valid, 2 malformed). Each beat runs
// through capture, step, pop check and send before the next input is
// accepted; the controller's pop loop over the per-level count registers
// runs once for each open container level that a completed element visits
// on its way up, and the send holds while the result is stalled.
module cbor_item_skip_validator #(
  parameter int unsigned MaxDepth   = cbv_pkg::MaxDepthDefault,
  parameter int unsigned LengthBits = cbv_pkg::LengthBitsDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic [15:0] bytes_after_i,
  input  wire logic        start_req_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       status_o
);
  import cbv_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequence each beat: capture, step, pop, send.
  cbv_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  // Hold head, argument, payload and nesting state.
  cbv_datapath #(.MaxDepth(MaxDepth), .LengthBits(LengthBits)) u_dp (
    .clk_i, .rst_ni, .data_byte_i, .bytes_after_i, .start_req_i,
    .cmd_i(cmd), .sts_o(sts), .status_o
  );
endmodule
`default_nettype wire

// ----- bench/tb_cbor_item_skip_validator.sv -----
`default_nettype none
module tb_cbor_item_skip_validator;
  timeunit 1ns;
  timeprecision 1ps;
  import cbv_pkg::*;

  localparam int unsigned Depth = MaxDepthDefault;
  localparam int unsigned WatchLimit = 5000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  data_byte_i = '0;
  logic [15:0] bytes_after_i = '0;
  logic        start_req_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  status_o;

  always #5 clk_i = ~clk_i;

  cbor_item_skip_validator u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .data_byte_i, .bytes_after_i,
    .start_req_i, .out_valid_o, .out_stall_i, .status_o
  );

  // Shadow state of the validator, kept at the block's own widths.
  phase_e      sh_phase;
  logic [2:0]  sh_major;
  logic [63:0] sh_arg;
  logic [3:0]  sh_arg_left;
  logic [3:0]  sh_arg_width;
  logic [15:0] sh_payload_left;
  logic [16:0] sh_counts [Depth];
  logic [4:0]  sh_level;

  status_e     status_q [$];   // statuses still owed by the block
  int          n_errors = 0;
  int          idle_pct = 36;  // current idling rate of both sides
  bit          rx_hold = 1'b0; // long receiver hold-off in progress

  task automatic report_mismatch(input string what);
    $display("mismatch @%0t: %s", $realtime, what);
    n_errors++;
  endtask

  function automatic status_e mark_bad();
    sh_phase = PH_ERR;
    return ST_BAD;
  endfunction

  // Close every container that a finished element completes.
  function automatic status_e close_element();
    while (sh_level > 0) begin
      if (sh_counts[sh_level-1] > 0) sh_counts[sh_level-1]--;
      if (sh_counts[sh_level-1] != 0) begin
        sh_phase = PH_HEAD;
        return ST_OPEN;
      end
      sh_level--;
    end
    sh_phase = PH_OK;
    return ST_VALID;
  endfunction

  function automatic status_e push_level(input logic [63:0] cnt);
    if (sh_level >= Depth) return mark_bad();
    sh_counts[sh_level] = cnt[16:0];
    sh_level++;
    sh_phase = PH_HEAD;
    return ST_OPEN;
  endfunction

  function automatic status_e finish_head(input logic [63:0] rem);
    logic [63:0] a;
    a = sh_arg;
    case (sh_major)
      3'd0: return close_element();
      3'd2, 3'd3: begin
        if (a > rem) return mark_bad();
        if (a == 0) return close_element();
        sh_payload_left = a[15:0];
        sh_phase = PH_PAYLOAD;
        return ST_OPEN;
      end
      3'd4: begin
        if (a > rem) return mark_bad();
        if (a == 0) return close_element();
        return push_level(a);
      end
      3'd5: begin
        if (a > rem / 2) return mark_bad();
        if (a == 0) return close_element();
        return push_level(a * 2);
      end
      3'd7: begin
        if (a == 20 || a == 21 || a == 22) return close_element();
        return mark_bad();
      end
      default: return mark_bad();
    endcase
  endfunction

  function automatic status_e predict_status(input logic [7:0] b,
                                             input logic [15:0] after,
                                             input logic start);
    logic [63:0] rem;
    logic [2:0]  mt;
    logic [4:0]  ai;
    logic [3:0]  need;
    status_e     st;
    rem = {48'd0, after};
    if (start) begin
      sh_level = 0;
      sh_arg_left = 0;
      sh_payload_left = 0;
      sh_phase = PH_HEAD;
    end
    case (sh_phase)
      PH_HEAD: begin
        mt = b[7:5];
        ai = b[4:0];
        if (sh_level + 1 > Depth || ai >= 28 || mt == 3'd1 || mt == 3'd6) begin
          st = mark_bad();
        end else begin
          need = (ai < 24) ? 4'd0 : 4'(1 << (ai - 24));
          if (need > rem) st = mark_bad();
          else begin
            sh_major = mt;
            if (need == 0) begin
              sh_arg = {59'd0, ai};
              st = finish_head(rem);
            end else begin
              sh_arg = 0;
              sh_arg_left = need;
              sh_arg_width = need;
              sh_phase = PH_ARG;
              st = ST_OPEN;
            end
          end
        end
      end
      PH_ARG: begin
        sh_arg = (sh_arg << 8) | b;
        if (sh_arg_left > 0) sh_arg_left--;
        if (sh_arg_left != 0) st = ST_OPEN;
        else if (sh_major != 3'd7 &&
                 ((sh_arg_width == 1 && sh_arg < 24) ||
                  (sh_arg_width == 2 && sh_arg <= 64'hff) ||
                  (sh_arg_width == 4 && sh_arg <= 64'hffff) ||
                  (sh_arg_width == 8 && sh_arg <= 64'hffff_ffff)))
          st = mark_bad();
        else st = finish_head(rem);
      end
      PH_PAYLOAD: begin
        if (sh_payload_left > 0) sh_payload_left--;
        st = (sh_payload_left == 0) ? close_element() : ST_OPEN;
      end
      PH_OK: return ST_VALID;
      default: return ST_BAD;
    endcase
    if (st == ST_OPEN && rem == 0) st = mark_bad();
    return st;
  endfunction

  // Offer one beat and hold it until the block takes it; drop valid only
  // while idling so that back-to-back beats keep it high.
  task automatic send_beat(input logic [7:0] b, input logic [15:0] after,
                           input logic start);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    data_byte_i   <= b;
    bytes_after_i <= after;
    start_req_i   <= start;
    do @(posedge clk_i); while (in_stall_o);
    status_q.push_back(predict_status(b, after, start));
  endtask

  // Directed rows; exp_st counts only where typed is set, other rows go by
  // the predictor.
  typedef struct {
    logic [7:0]  b;
    logic [15:0] after;
    logic        start;
    bit          typed;
    status_e     exp_st;
  } row_t;

  row_t dir_rows [] = '{
    '{8'h00, 16'd5, 1'b0, 1'b1, ST_BAD},    // byte before any item
    '{8'h00, 16'd0, 1'b1, 1'b1, ST_VALID},  // zero
    '{8'h00, 16'd0, 1'b0, 1'b1, ST_VALID},  // trailing byte repeats valid
    '{8'h20, 16'd3, 1'b1, 1'b1, ST_BAD},    // negative integer
    '{8'hc0, 16'd3, 1'b1, 1'b1, ST_BAD},    // tag
    '{8'h1c, 16'd9, 1'b1, 1'b1, ST_BAD},    // reserved info
    '{8'hff, 16'd9, 1'b1, 1'b1, ST_BAD},    // break byte
    '{8'hff, 16'd9, 1'b0, 1'b1, ST_BAD},    // trailing byte repeats error
    '{8'hf4, 16'hffff, 1'b1, 1'b1, ST_VALID}, // false
    '{8'hf7, 16'd0, 1'b1, 1'b1, ST_BAD},    // undefined simple
    '{8'h1b, 16'd7, 1'b1, 1'b1, ST_BAD},    // argument past the buffer
    '{8'h18, 16'd1, 1'b1, 1'b0, ST_OPEN},   // non-shortest uint
    '{8'h17, 16'd0, 1'b0, 1'b0, ST_OPEN},
    '{8'hf8, 16'd1, 1'b1, 1'b0, ST_OPEN},   // simple with extension byte
    '{8'h16, 16'd0, 1'b0, 1'b0, ST_OPEN},
    '{8'h82, 16'd3, 1'b1, 1'b0, ST_OPEN},   // array, abandoned by new start
    '{8'hbf, 16'd3, 1'b1, 1'b1, ST_BAD},
    '{8'ha1, 16'd2, 1'b1, 1'b0, ST_OPEN},   // map of one pair with a one-byte text key
    '{8'h61, 16'd1, 1'b0, 1'b0, ST_OPEN},
    '{8'hfe, 16'd0, 1'b0, 1'b0, ST_OPEN},   // string payload at buffer end
    '{8'h43, 16'd2, 1'b1, 1'b1, ST_BAD},    // string longer than buffer
    '{8'h59, 16'd5, 1'b1, 1'b0, ST_OPEN},   // 16-bit length
    '{8'h01, 16'd4, 1'b0, 1'b0, ST_OPEN},
    '{8'h00, 16'd3, 1'b0, 1'b0, ST_OPEN}
  };

  // Build one random item's bytes; mostly well formed.
  task automatic gen_item(ref logic [7:0] bytes [$], input int depth);
    int kind, n;
    kind = $urandom_range(9);
    if (depth > Depth + 1) kind = 0;
    case (kind)
      0, 1: begin
        n = $urandom_range(3);
        if (n == 0) bytes.push_back(8'($urandom_range(23)));
        else if (n == 1) begin
          bytes.push_back(8'h18); bytes.push_back(8'($urandom_range(255, 24)));
        end else if (n == 2) begin
          bytes.push_back(8'h19); bytes.push_back(8'($urandom_range(255, 1)));
          bytes.push_back(8'($urandom));
        end else begin
          bytes.push_back(8'h1a + 8'($urandom_range(1)));
          repeat (bytes[$] == 8'h1a ? 4 : 8) bytes.push_back(8'($urandom));
        end
      end
      2, 3: begin
        n = $urandom_range(4);
        bytes.push_back({2'b01, 1'($urandom), 5'(n)});
        repeat (n) bytes.push_back(8'($urandom));
      end
      4: bytes.push_back(8'($urandom_range(22, 20)) | 8'he0);
      5, 6: begin
        n = (depth > 4 && $urandom_range(3) != 0) ? 1 : $urandom_range(3);
        bytes.push_back(8'h80 | 8'(n));
        repeat (n) gen_item(bytes, depth + 1);
      end
      7, 8: begin
        n = $urandom_range(2);
        bytes.push_back(8'ha0 | 8'(n));
        repeat (2 * n) gen_item(bytes, depth + 1);
      end
      default: bytes.push_back(8'($urandom));  // noise
    endcase
  endtask

  // Receiver: random stall plus one long hold-off.
  always @(posedge clk_i) begin
    if (rx_hold) out_stall_i <= 1'b1;
    else out_stall_i <= ($urandom_range(99) < idle_pct);
  end

  // Compare each accepted status beat with the oldest owed one.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (status_q.size() == 0) report_mismatch("status beat with nothing owed");
      else begin
        status_e want;
        want = status_q.pop_front();
        if (status_o !== want)
          report_mismatch($sformatf("status %0d, want %0d", status_o, want));
      end
    end
  end

  // Watchdog: count cycles with no handshake on either side.
  int quiet = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WatchLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    logic [7:0] bytes [$];
    int cnt, cut;
    bit hold_done, pause_done;
    hold_done = 1'b0;
    pause_done = 1'b0;
    sh_phase = PH_IDLE; sh_major = 0; sh_arg = 0; sh_arg_left = 0;
    sh_arg_width = 0; sh_payload_left = 0; sh_level = 0;
    foreach (sh_counts[i]) sh_counts[i] = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table: check typed rows against the shadow too.
    foreach (dir_rows[i]) begin
      send_beat(dir_rows[i].b, dir_rows[i].after, dir_rows[i].start);
      if (dir_rows[i].typed && status_q[$] != dir_rows[i].exp_st)
        report_mismatch($sformatf("row %0d prediction disagrees with table", i));
      if (dir_rows[i].typed) status_q[$] = dir_rows[i].exp_st;
    end

    // Random items; a no-idle stretch, a long receiver hold-off and a drain pause midway.
    cnt = 0;
    while (cnt < 800) begin
      if (cnt >= 250 && cnt < 350) idle_pct = 0;
      else idle_pct = 36;
      if (cnt >= 400 && !hold_done) begin
        hold_done = 1'b1;
        fork
          begin
            rx_hold = 1'b1;
            repeat (300) @(posedge clk_i);
            rx_hold = 1'b0;
          end
        join_none
      end
      if (cnt >= 600 && !pause_done) begin
        pause_done = 1'b1;
        in_valid_i <= 1'b0;
        wait (status_q.size() == 0);
      end
      bytes.delete();
      gen_item(bytes, 1);
      // Occasionally truncate, pad, or make the buffer deliberately short.
      cut = bytes.size();
      if ($urandom_range(9) == 0 && cut > 1) cut = $urandom_range(cut - 1, 1);
      if ($urandom_range(9) == 0) repeat ($urandom_range(2, 1)) bytes.push_back(8'($urandom));
      for (int k = 0; k < bytes.size(); k++) begin
        logic [15:0] after;
        after = (k < cut) ? 16'(cut - 1 - k) : 16'd0;
        if ($urandom_range(49) == 0) after = 16'($urandom);
        send_beat(bytes[k], after, k == 0);
        cnt++;
      end
    end
    in_valid_i <= 1'b0;
    idle_pct = 36;
    wait (status_q.size() == 0);
    repeat (50) @(posedge clk_i);
    if (n_errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
`default_nettype wire
